>>> hdl/tai_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle adjacency index builder package
// Shared constants, codes and beat types for the index builder and its cells.
// ----------------------------------------------------------------------------
package tai_pkg;

  // Store depth and the widths that follow from it.
  localparam int MaxTriangles = 1024;
  localparam int IdxW         = $clog2(MaxTriangles);
  localparam int CntW         = $clog2(MaxTriangles + 1);
  localparam int VtxW         = 32;

  // Number of list entries in each fetch mode.
  localparam logic [2:0] CountAdj   = 3'd6;
  localparam logic [2:0] CountPlain = 3'd3;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FETCH = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Status codes of a result beat.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // One stored triangle.
  typedef struct packed {
    logic [VtxW-1:0] va;
    logic [VtxW-1:0] vb;
    logic [VtxW-1:0] vc;
  } tri_t;

  // Input beat.
  typedef struct packed {
    logic [1:0]      opcode;
    logic [VtxW-1:0] vertex_a;
    logic [VtxW-1:0] vertex_b;
    logic [VtxW-1:0] vertex_c;
    logic [9:0]      triangle_number;
  } in_t;

  // Result beat.
  typedef struct packed {
    status_e         status;
    logic [2:0]      index_count;
    logic [VtxW-1:0] list_0;
    logic [VtxW-1:0] list_1;
    logic [VtxW-1:0] list_2;
    logic [VtxW-1:0] list_3;
    logic [VtxW-1:0] list_4;
    logic [VtxW-1:0] list_5;
    logic [CntW-1:0] loaded_count;
  } out_t;

  // Stored word travelling along the match chain.
  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
    tri_t            verts;
  } word_t;

  // Key set-up for one match cell.
  typedef struct packed {
    logic            load;
    logic [VtxW-1:0] from;
    logic [VtxW-1:0] to;
    logic [IdxW-1:0] tri_num;
    logic [1:0]      slot;
  } key_t;

endpackage

>>> hdl/tai_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle store
// One write port and one registered read port over the loaded triangles.
// ----------------------------------------------------------------------------
module tai_store (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [tai_pkg::IdxW-1:0]  waddr_i,
  input  tai_pkg::tri_t             wdata_i,
  input  logic [tai_pkg::IdxW-1:0]  raddr_i,
  output tai_pkg::tri_t             rdata_o
);

  tai_pkg::tri_t mem [tai_pkg::MaxTriangles];
  tai_pkg::tri_t rdata_q;

  // Write on load, read every cycle into the output register.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/tai_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge match cell
// Holds one directed edge of the fetched triangle, tracks the last holder of
// that edge and of its reverse over the scanned words, and passes each word on.
// ----------------------------------------------------------------------------
module tai_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tai_pkg::key_t             key_i,
  input  tai_pkg::word_t            word_i,
  output tai_pkg::word_t            word_o,
  output logic [tai_pkg::VtxW-1:0]  adj_o
);

  logic [tai_pkg::VtxW-1:0] key_from_q;
  logic [tai_pkg::VtxW-1:0] key_to_q;
  logic [tai_pkg::IdxW-1:0] key_tri_q;
  logic [1:0]               key_slot_q;
  logic                     own_q;
  logic                     found_q;
  logic [tai_pkg::VtxW-1:0] vert_q;
  tai_pkg::word_t           word_q;

  logic [tai_pkg::VtxW-1:0] e_from [3];
  logic [tai_pkg::VtxW-1:0] e_to   [3];
  logic [tai_pkg::VtxW-1:0] e_vert [3];
  logic                     f_hit;
  logic                     r_hit;
  logic [1:0]               f_slot;
  logic [1:0]               r_slot;

  // Slot edges of the incoming word and the vertex that each slot carries.
  always_comb begin
    e_from[0] = word_i.verts.vc;
    e_to[0]   = word_i.verts.va;
    e_vert[0] = word_i.verts.vb;
    e_from[1] = word_i.verts.va;
    e_to[1]   = word_i.verts.vb;
    e_vert[1] = word_i.verts.vc;
    e_from[2] = word_i.verts.vb;
    e_to[2]   = word_i.verts.vc;
    e_vert[2] = word_i.verts.va;
  end

  // The highest matching slot wins within a word.
  always_comb begin
    f_hit  = 1'b0;
    r_hit  = 1'b0;
    f_slot = 2'd0;
    r_slot = 2'd0;
    for (int j = 0; j < 3; j++) begin
      if (e_from[j] == key_from_q && e_to[j] == key_to_q) begin
        f_hit  = 1'b1;
        f_slot = 2'(j);
      end
      if (e_from[j] == key_to_q && e_to[j] == key_from_q) begin
        r_hit  = 1'b1;
        r_slot = 2'(j);
      end
    end
  end

  // Key registers are loaded once per adjacency fetch.
  always_ff @(posedge clk_i) begin
    if (key_i.load) begin
      key_from_q <= key_i.from;
      key_to_q   <= key_i.to;
      key_tri_q  <= key_i.tri_num;
      key_slot_q <= key_i.slot;
    end
    if (word_i.valid && r_hit) begin
      vert_q <= e_vert[r_slot];
    end
  end

  // Words arrive in ascending order, so the latest match is the holder.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q   <= 1'b0;
      found_q <= 1'b0;
      word_q  <= '0;
    end else begin
      word_q <= word_i;
      if (key_i.load) begin
        own_q   <= 1'b0;
        found_q <= 1'b0;
      end else if (word_i.valid) begin
        if (f_hit) begin
          own_q <= (word_i.idx == key_tri_q) && (f_slot == key_slot_q);
        end
        if (r_hit) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  assign word_o = word_q;
  assign adj_o  = (own_q && found_q) ? vert_q : key_from_q;

endmodule

>>> hdl/triangle_adjacency_index_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle adjacency index builder
// Loads triangles into a store and answers fetches with plain or adjacency
// index lists, matching edges through a chain of three cells.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Payload
//  in       input      in_valid_i / in_stall_o    in_data_i   (tai_pkg::in_t)
//  out      output     out_valid_o / out_stall_i  out_data_o  (tai_pkg::out_t)
//  cfg      input      cfg_wr_en_i                cfg_wr_data_i (adjacency enable)
//
// Load, clear, unused codes and out-of-range fetches go from idle to emit; a
// plain fetch passes read, latch and emit. An adjacency fetch passes read,
// latch, scan, drain and emit, the single store read port feeding one word a
// cycle into the match chain. Reset empties the store count and disables
// adjacency; the store contents are left undefined. A new beat is taken while
// the previous result still waits in the output register behind a stall.
// ----------------------------------------------------------------------------
module triangle_adjacency_index_builder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tai_pkg::in_t     in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tai_pkg::out_t    out_data_o,
  input  logic             cfg_wr_en_i,
  input  logic             cfg_wr_data_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_LATCH = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  state_e                        state_q, state_d;
  logic [tai_pkg::CntW-1:0]      total_q, total_d;
  logic                          adj_q;
  logic [tai_pkg::IdxW-1:0]      t_q, t_d;
  tai_pkg::tri_t                 tri_q, tri_d;
  logic [tai_pkg::IdxW-1:0]      scan_q, scan_d;
  logic                          iss_v_q, iss_v_d;
  logic [tai_pkg::IdxW-1:0]      iss_idx_q, iss_idx_d;
  tai_pkg::out_t                 res_q, res_d;
  logic                          out_valid_q, out_valid_d;
  tai_pkg::out_t                 out_q, out_d;

  logic                          in_accept;
  logic                          out_free;
  logic [tai_pkg::CntW-1:0]      total_m1;
  logic                          mem_we;
  logic [tai_pkg::IdxW-1:0]      mem_raddr;
  tai_pkg::tri_t                 mem_wdata;
  tai_pkg::tri_t                 mem_rdata;
  tai_pkg::key_t                 keys [3];
  tai_pkg::word_t                chain [4];
  logic [tai_pkg::VtxW-1:0]      adj [3];
  logic                          drain_done;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign total_m1   = total_q - tai_pkg::CntW'(1);

  // Triangle store.
  assign mem_wdata = '{va: in_data_i.vertex_a, vb: in_data_i.vertex_b,
                       vc: in_data_i.vertex_c};
  assign mem_raddr = (state_q == S_SCAN) ? scan_q : t_q;

  tai_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (total_q[tai_pkg::IdxW-1:0]),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Keys of the fetched triangle's three directed edges.
  always_comb begin
    for (int s = 0; s < 3; s++) begin
      keys[s].load    = (state_q == S_LATCH) && adj_q;
      keys[s].tri_num = t_q;
      keys[s].slot    = 2'(s);
    end
    keys[0].from = mem_rdata.vc;
    keys[0].to   = mem_rdata.va;
    keys[1].from = mem_rdata.va;
    keys[1].to   = mem_rdata.vb;
    keys[2].from = mem_rdata.vb;
    keys[2].to   = mem_rdata.vc;
  end

  // Match chain: each scanned word passes through the three cells in turn.
  assign chain[0] = '{valid: iss_v_q, idx: iss_idx_q, verts: mem_rdata};

  for (genvar g = 0; g < 3; g++) begin : g_cell
    tai_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (keys[g]),
      .word_i (chain[g]),
      .word_o (chain[g+1]),
      .adj_o  (adj[g])
    );
  end

  assign drain_done = !iss_v_q && !chain[1].valid && !chain[2].valid &&
                      !chain[3].valid;

  // Sequencer and result assembly.
  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    t_d         = t_q;
    tri_d       = tri_q;
    scan_d      = scan_q;
    iss_v_d     = 1'b0;
    iss_idx_d   = scan_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_d        = '0;
          res_d.status = tai_pkg::ST_OK;
          t_d          = in_data_i.triangle_number;
          state_d      = S_EMIT;
          case (in_data_i.opcode)
            tai_pkg::OP_LOAD: begin
              if (total_q == tai_pkg::CntW'(tai_pkg::MaxTriangles)) begin
                res_d.status = tai_pkg::ST_FULL;
              end else begin
                mem_we  = 1'b1;
                total_d = total_q + tai_pkg::CntW'(1);
              end
            end
            tai_pkg::OP_FETCH: begin
              if ({1'b0, in_data_i.triangle_number} >= total_q) begin
                res_d.status = tai_pkg::ST_RANGE;
              end else begin
                state_d = S_READ;
              end
            end
            tai_pkg::OP_CLEAR: begin
              total_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        state_d = S_LATCH;
      end
      S_LATCH: begin
        tri_d = mem_rdata;
        if (adj_q) begin
          scan_d  = '0;
          state_d = S_SCAN;
        end else begin
          res_d.index_count = tai_pkg::CountPlain;
          res_d.list_0      = mem_rdata.va;
          res_d.list_1      = mem_rdata.vb;
          res_d.list_2      = mem_rdata.vc;
          state_d           = S_EMIT;
        end
      end
      S_SCAN: begin
        iss_v_d   = 1'b1;
        iss_idx_d = scan_q;
        scan_d    = scan_q + tai_pkg::IdxW'(1);
        if (scan_q == total_m1[tai_pkg::IdxW-1:0]) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_done) begin
          res_d.index_count = tai_pkg::CountAdj;
          res_d.list_0      = tri_q.vc;
          res_d.list_1      = adj[0];
          res_d.list_2      = tri_q.va;
          res_d.list_3      = adj[1];
          res_d.list_4      = tri_q.vb;
          res_d.list_5      = adj[2];
          state_d           = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_d              = res_q;
          out_d.loaded_count = total_q;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      adj_q       <= 1'b0;
      iss_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      iss_v_q     <= iss_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr_en_i) begin
        adj_q <= cfg_wr_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    t_q       <= t_d;
    tri_q     <= tri_d;
    scan_q    <= scan_d;
    iss_idx_q <= iss_idx_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
